### src/pid_speed_regulator_ff_top_assert.svh
// assertion shorthands for the speed regulator
`ifndef PID_SPEED_REGULATOR_FF_TOP_ASSERT_SVH
`define PID_SPEED_REGULATOR_FF_TOP_ASSERT_SVH

// same-cycle implication, checked out of reset
`define PIDFF_ASSERT_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, checked out of reset
`define PIDFF_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### src/pidff_pkg.sv
package pidff_pkg;

	// shared multiply/divide unit widths
	localparam int MDU_W     = 72;
	localparam int MDU_AW    = 48;
	localparam int MDU_BW    = 24;
	localparam int MUL_STEPS = 24;
	localparam int DIV_STEPS = 72;
	localparam int CNT_W     = 7;

	// fixed scale factors
	localparam logic [15:0] DT_DEFAULT  = 16'd50;
	localparam logic [23:0] MS_PER_S    = 24'd1000;
	localparam logic [23:0] DERIV_SCALE = 24'd256000;

	typedef enum logic {
		MDU_MUL,
		MDU_DIV
	} mdu_op_t;

	typedef struct packed {
		logic    start;
		mdu_op_t op;
	} mdu_req_t;

	typedef enum logic [2:0] {
		CFG_TARGET_RPM = 3'd0,
		CFG_GAIN_P     = 3'd1,
		CFG_GAIN_I     = 3'd2,
		CFG_GAIN_D     = 3'd3,
		CFG_GAIN_FF    = 3'd4,
		CFG_PWM_LOW    = 3'd5,
		CFG_PWM_HIGH   = 3'd6,
		CFG_TAU_MS     = 3'd7
	} cfg_idx_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_EI_MUL,
		ST_P_MUL,
		ST_FF_MUL,
		ST_I_MUL,
		ST_I_DIV,
		ST_I_CMP,
		ST_BC_MUL,
		ST_BC_DIV,
		ST_RAW_MUL,
		ST_RAW_DIV,
		ST_F_MUL,
		ST_F_DIV,
		ST_D_MUL,
		ST_SUM,
		ST_OUT
	} seq_state_t;

endpackage

### src/pidff_mdu.sv
module pidff_mdu (
	input  logic                            clk,
	input  logic                            arst_n,
	input  pidff_pkg::mdu_req_t             req,
	input  logic [pidff_pkg::MDU_W-1:0]     a,
	input  logic [pidff_pkg::MDU_BW-1:0]    b,
	output logic                            done,
	output logic [pidff_pkg::MDU_W-1:0]     result
);

	logic                            busy_q;
	logic                            done_q;
	logic [pidff_pkg::CNT_W-1:0]     cnt_q;
	pidff_pkg::mdu_op_t              op_q;
	logic [pidff_pkg::MDU_W-1:0]     sh_q;
	logic [pidff_pkg::MDU_AW-1:0]    opd_q;
	logic [pidff_pkg::MDU_BW-1:0]    rem_q;

	logic [pidff_pkg::MDU_AW:0]      msum;
	logic [pidff_pkg::MDU_BW:0]      r2;
	logic [pidff_pkg::MDU_BW:0]      rdiff;
	logic                            ge;

	// one multiplier bit: add multiplicand into the high half, shift right
	assign msum = {1'b0, sh_q[pidff_pkg::MDU_W-1:pidff_pkg::MDU_BW]}
		+ (sh_q[0] ? {1'b0, opd_q} : '0);

	// one quotient bit: restoring compare and subtract
	assign r2    = {rem_q, sh_q[pidff_pkg::MDU_W-1]};
	assign rdiff = r2 - {1'b0, opd_q[pidff_pkg::MDU_BW-1:0]};
	assign ge    = (r2 >= {1'b0, opd_q[pidff_pkg::MDU_BW-1:0]});

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= (req.op == pidff_pkg::MDU_MUL)
					? pidff_pkg::CNT_W'(pidff_pkg::MUL_STEPS - 1)
					: pidff_pkg::CNT_W'(pidff_pkg::DIV_STEPS - 1);
			end else if (busy_q) begin
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q - 1'b1;
				end
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (req.start) begin
			op_q  <= req.op;
			rem_q <= '0;
			if (req.op == pidff_pkg::MDU_MUL) begin
				sh_q  <= {{(pidff_pkg::MDU_W - pidff_pkg::MDU_BW){1'b0}}, b};
				opd_q <= a[pidff_pkg::MDU_AW-1:0];
			end else begin
				sh_q  <= a;
				opd_q <= {{(pidff_pkg::MDU_AW - pidff_pkg::MDU_BW){1'b0}}, b};
			end
		end else if (busy_q) begin
			if (op_q == pidff_pkg::MDU_MUL) begin
				sh_q <= {msum, sh_q[pidff_pkg::MDU_BW-1:1]};
			end else begin
				sh_q  <= {sh_q[pidff_pkg::MDU_W-2:0], ge};
				rem_q <= ge ? rdiff[pidff_pkg::MDU_BW-1:0] : r2[pidff_pkg::MDU_BW-1:0];
			end
		end
	end

	assign done   = done_q;
	assign result = sh_q;

endmodule

### src/pid_speed_regulator_ff_top.sv
// PID speed regulator with feed-forward and back-calculation anti-windup.
// Each transfer on the input stream brings a measured speed and the elapsed
// milliseconds (0 means 50 ms) and yields one duty value with two flags.
// All products and quotients go through one shared unit that handles a
// multiplier bit or a quotient bit per cycle. With gain_i at zero the integral
// steps are skipped; otherwise the integral product is divided and compared
// with its headroom, and when it is limited a back-calculation multiply and
// divide follow. The next item is taken while the previous result still waits
// at the output register. Write configuration only while no item is in flight.
`include "pid_speed_regulator_ff_top_assert.svh"

module pid_speed_regulator_ff_top (
	input  logic        clk,
	input  logic        arst_n,
	// configuration write channel
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [23:0] cfg_data,
	// input stream
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [31:0] s_axis_tdata,  // measured_rpm[15:0], elapsed_ms[31:16]
	// result stream
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [15:0] m_axis_tdata   // pwm_duty[7:0], integral_clamped[8],
	                                   // output_saturated[9], zero fill
);

	// configuration registers
	logic [14:0] target_q;
	logic [23:0] gain_p_q, gain_i_q, gain_d_q, gain_ff_q;
	logic [7:0]  pwm_low_q, pwm_high_q;
	logic [15:0] tau_q;

	// controller state and per-item terms
	pidff_pkg::seq_state_t st_q, st_d;
	logic signed [17:0] e_q, prev_q;
	logic [15:0]        dt_q;
	logic signed [47:0] ei_q;
	logic signed [39:0] f_q, raw_q;
	logic signed [51:0] p_q, pf_q, iterm_q, dterm_q, sum_q;
	logic               iclamp_q;
	logic               issued_q;

	// result register
	logic       m_valid_q;
	logic [7:0] duty_q;
	logic       iclamp_out_q, osat_q;

	// shared unit
	pidff_pkg::mdu_req_t mdu_req;
	logic [71:0]         mdu_a;
	logic [23:0]         mdu_b;
	logic                mdu_done;
	logic [71:0]         res;

	logic               in_xfer, out_free;
	logic               op_state;
	logic signed [15:0] meas;
	logic signed [17:0] e_in;
	logic [16:0]        e_mag;
	logic signed [18:0] diff;
	logic [17:0]        diff_mag;
	logic [47:0]        ei_mag, it_mag;
	logic signed [40:0] t;
	logic [39:0]        t_mag, f_mag;
	logic signed [49:0] ei_term, ei_sum;
	logic [47:0]        ei_sat;
	logic               ibig, bcpos_big, bcneg_big, dbig;
	logic [47:0]        imag, dmag;
	logic signed [51:0] hi_lim, lo_lim, maxi, mini, sum1;
	logic               icmp_hi, icmp_lo, osat1;

	assign cfg_ready     = 1'b1;
	assign s_axis_tready = (st_q == pidff_pkg::ST_IDLE);
	assign in_xfer       = s_axis_tvalid && s_axis_tready;
	assign out_free      = !m_valid_q || m_axis_tready;

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			target_q   <= '0;
			gain_p_q   <= '0;
			gain_i_q   <= '0;
			gain_d_q   <= '0;
			gain_ff_q  <= '0;
			pwm_low_q  <= '0;
			pwm_high_q <= 8'd255;
			tau_q      <= 16'd20;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				pidff_pkg::CFG_TARGET_RPM: target_q   <= cfg_data[14:0];
				pidff_pkg::CFG_GAIN_P:     gain_p_q   <= cfg_data;
				pidff_pkg::CFG_GAIN_I:     gain_i_q   <= cfg_data;
				pidff_pkg::CFG_GAIN_D:     gain_d_q   <= cfg_data;
				pidff_pkg::CFG_GAIN_FF:    gain_ff_q  <= cfg_data;
				pidff_pkg::CFG_PWM_LOW:    pwm_low_q  <= cfg_data[7:0];
				pidff_pkg::CFG_PWM_HIGH:   pwm_high_q <= cfg_data[7:0];
				pidff_pkg::CFG_TAU_MS:     tau_q      <= cfg_data[15:0];
			endcase
		end
	end

	// error of the incoming sample
	assign meas = $signed(s_axis_tdata[15:0]);
	assign e_in = $signed({3'b000, target_q}) - $signed({{2{meas[15]}}, meas});

	// magnitudes of the signed terms
	assign e_mag    = e_q[17] ? 17'(~e_q + 18'd1) : e_q[16:0];
	assign diff     = $signed({e_q[17], e_q}) - $signed({prev_q[17], prev_q});
	assign diff_mag = diff[18] ? 18'(~diff + 19'd1) : diff[17:0];
	assign ei_mag   = ei_q[47] ? (~ei_q + 48'd1) : ei_q;
	assign it_mag   = iterm_q[51] ? 48'(~iterm_q + 52'd1) : iterm_q[47:0];
	assign t        = $signed({raw_q[39], raw_q}) - $signed({f_q[39], f_q});
	assign t_mag    = t[40] ? 40'(~t + 41'd1) : t[39:0];
	assign f_mag    = f_q[39] ? (~f_q + 40'd1) : f_q;

	// accumulator update, saturated to 48 bits
	assign ei_term = e_q[17] ? -$signed({17'b0, res[32:0]}) : $signed({17'b0, res[32:0]});
	assign ei_sum  = $signed({{2{ei_q[47]}}, ei_q}) + ei_term;
	assign ei_sat  = (ei_sum[49:47] == 3'b000 || ei_sum[49:47] == 3'b111) ? ei_sum[47:0]
		: (ei_sum[49] ? 48'h8000_0000_0000 : 48'h7FFF_FFFF_FFFF);

	// magnitude limits of the integral, back-calculation and derivative terms
	assign ibig      = (|res[71:48]) || (res[47] && (|res[46:0]));
	assign imag      = ibig ? 48'h8000_0000_0000 : res[47:0];
	assign bcpos_big = |res[71:47];
	assign bcneg_big = ibig;
	assign dbig      = (|res[71:56]) || (res[55] && (|res[54:8]));
	assign dmag      = dbig ? 48'h8000_0000_0000 : res[55:8];

	// headroom for the integral term
	assign hi_lim  = $signed({28'b0, pwm_high_q, 16'b0});
	assign lo_lim  = $signed({28'b0, pwm_low_q, 16'b0});
	assign maxi    = hi_lim - pf_q;
	assign mini    = lo_lim - pf_q;
	assign icmp_hi = iterm_q > maxi;
	assign icmp_lo = iterm_q < mini;

	// output clamp: high first, then low
	assign osat1 = sum_q > hi_lim;
	assign sum1  = osat1 ? hi_lim : sum_q;

	// operand selection for the shared unit
	always_comb begin
		op_state   = 1'b1;
		mdu_req.op = pidff_pkg::MDU_MUL;
		mdu_a      = res;
		mdu_b      = '0;
		unique case (st_q)
			pidff_pkg::ST_EI_MUL: begin
				mdu_a = 72'(e_mag);
				mdu_b = 24'(dt_q);
			end
			pidff_pkg::ST_P_MUL: begin
				mdu_a = 72'(e_mag);
				mdu_b = gain_p_q;
			end
			pidff_pkg::ST_FF_MUL: begin
				mdu_a = 72'(target_q);
				mdu_b = gain_ff_q;
			end
			pidff_pkg::ST_I_MUL: begin
				mdu_a = 72'(ei_mag);
				mdu_b = gain_i_q;
			end
			pidff_pkg::ST_I_DIV: begin
				mdu_req.op = pidff_pkg::MDU_DIV;
				mdu_b      = pidff_pkg::MS_PER_S;
			end
			pidff_pkg::ST_BC_MUL: begin
				mdu_a = 72'(it_mag);
				mdu_b = pidff_pkg::MS_PER_S;
			end
			pidff_pkg::ST_BC_DIV: begin
				mdu_req.op = pidff_pkg::MDU_DIV;
				mdu_b      = gain_i_q;
			end
			pidff_pkg::ST_RAW_MUL: begin
				mdu_a = 72'(diff_mag);
				mdu_b = pidff_pkg::DERIV_SCALE;
			end
			pidff_pkg::ST_RAW_DIV: begin
				mdu_req.op = pidff_pkg::MDU_DIV;
				mdu_b      = 24'(dt_q);
			end
			pidff_pkg::ST_F_MUL: begin
				mdu_a = 72'(t_mag);
				mdu_b = 24'(dt_q);
			end
			pidff_pkg::ST_F_DIV: begin
				mdu_req.op = pidff_pkg::MDU_DIV;
				mdu_b      = 24'({1'b0, tau_q} + {1'b0, dt_q});
			end
			pidff_pkg::ST_D_MUL: begin
				mdu_a = 72'(f_mag);
				mdu_b = gain_d_q;
			end
			default: op_state = 1'b0;
		endcase
		mdu_req.start = op_state && !issued_q;
	end

	pidff_mdu u_mdu (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (mdu_req),
		.a      (mdu_a),
		.b      (mdu_b),
		.done   (mdu_done),
		.result (res)
	);

	// sequencer state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= pidff_pkg::ST_IDLE;
		end else begin
			st_q <= st_d;
		end
	end

	// sequencer next state
	always_comb begin
		st_d = st_q;
		unique case (st_q)
			pidff_pkg::ST_IDLE:    if (in_xfer) st_d = pidff_pkg::ST_EI_MUL;
			pidff_pkg::ST_EI_MUL:  if (mdu_done) st_d = pidff_pkg::ST_P_MUL;
			pidff_pkg::ST_P_MUL:   if (mdu_done) st_d = pidff_pkg::ST_FF_MUL;
			pidff_pkg::ST_FF_MUL: begin
				if (mdu_done) begin
					st_d = (gain_i_q == '0) ? pidff_pkg::ST_RAW_MUL : pidff_pkg::ST_I_MUL;
				end
			end
			pidff_pkg::ST_I_MUL:   if (mdu_done) st_d = pidff_pkg::ST_I_DIV;
			pidff_pkg::ST_I_DIV:   if (mdu_done) st_d = pidff_pkg::ST_I_CMP;
			pidff_pkg::ST_I_CMP: begin
				st_d = (icmp_hi || icmp_lo) ? pidff_pkg::ST_BC_MUL : pidff_pkg::ST_RAW_MUL;
			end
			pidff_pkg::ST_BC_MUL:  if (mdu_done) st_d = pidff_pkg::ST_BC_DIV;
			pidff_pkg::ST_BC_DIV:  if (mdu_done) st_d = pidff_pkg::ST_RAW_MUL;
			pidff_pkg::ST_RAW_MUL: if (mdu_done) st_d = pidff_pkg::ST_RAW_DIV;
			pidff_pkg::ST_RAW_DIV: if (mdu_done) st_d = pidff_pkg::ST_F_MUL;
			pidff_pkg::ST_F_MUL:   if (mdu_done) st_d = pidff_pkg::ST_F_DIV;
			pidff_pkg::ST_F_DIV:   if (mdu_done) st_d = pidff_pkg::ST_D_MUL;
			pidff_pkg::ST_D_MUL:   if (mdu_done) st_d = pidff_pkg::ST_SUM;
			pidff_pkg::ST_SUM:     st_d = pidff_pkg::ST_OUT;
			pidff_pkg::ST_OUT:     if (out_free) st_d = pidff_pkg::ST_IDLE;
		endcase
	end

	// control state: unit handshake, loop state, result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			issued_q  <= 1'b0;
			m_valid_q <= 1'b0;
			ei_q      <= '0;
			prev_q    <= '0;
			f_q       <= '0;
		end else begin
			if (mdu_req.start) begin
				issued_q <= 1'b1;
			end else if (mdu_done) begin
				issued_q <= 1'b0;
			end
			if (st_q == pidff_pkg::ST_OUT && out_free) begin
				m_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				m_valid_q <= 1'b0;
			end
			if (mdu_done && st_q == pidff_pkg::ST_EI_MUL) begin
				ei_q <= ei_sat;
			end
			if (mdu_done && st_q == pidff_pkg::ST_FF_MUL && gain_i_q == '0) begin
				ei_q <= '0;
			end
			if (mdu_done && st_q == pidff_pkg::ST_BC_DIV) begin
				if (iterm_q[51]) begin
					ei_q <= bcneg_big ? 48'h8000_0000_0000 : (~res[47:0] + 48'd1);
				end else begin
					ei_q <= bcpos_big ? 48'h7FFF_FFFF_FFFF : res[47:0];
				end
			end
			if (mdu_done && st_q == pidff_pkg::ST_F_DIV) begin
				f_q <= f_q + (t[40] ? -$signed({1'b0, res[38:0]}) : $signed({1'b0, res[38:0]}));
			end
			if (st_q == pidff_pkg::ST_OUT && out_free) begin
				prev_q <= e_q;
			end
		end
	end

	// per-item terms
	always_ff @(posedge clk) begin
		if (in_xfer) begin
			e_q  <= e_in;
			dt_q <= (s_axis_tdata[31:16] == '0) ? pidff_pkg::DT_DEFAULT : s_axis_tdata[31:16];
		end
		if (mdu_done) begin
			unique case (st_q)
				pidff_pkg::ST_P_MUL: begin
					p_q <= e_q[17] ? -$signed({11'b0, res[40:0]}) : $signed({11'b0, res[40:0]});
				end
				pidff_pkg::ST_FF_MUL: begin
					pf_q     <= p_q + $signed({13'b0, res[38:0]});
					iterm_q  <= '0;
					iclamp_q <= 1'b0;
				end
				pidff_pkg::ST_I_DIV: begin
					iterm_q <= ei_q[47] ? -$signed({4'b0, imag}) : $signed({4'b0, imag});
				end
				pidff_pkg::ST_RAW_DIV: begin
					raw_q <= diff[18] ? -$signed({1'b0, res[38:0]}) : $signed({1'b0, res[38:0]});
				end
				pidff_pkg::ST_D_MUL: begin
					dterm_q <= f_q[39] ? -$signed({4'b0, dmag}) : $signed({4'b0, dmag});
				end
				default: ;
			endcase
		end
		// integral limited to the headroom, upper side first
		if (st_q == pidff_pkg::ST_I_CMP) begin
			if (icmp_hi) begin
				iterm_q  <= maxi;
				iclamp_q <= 1'b1;
			end else if (icmp_lo) begin
				iterm_q  <= mini;
				iclamp_q <= 1'b1;
			end
		end
		if (st_q == pidff_pkg::ST_SUM) begin
			sum_q <= pf_q + iterm_q + dterm_q;
		end
		if (st_q == pidff_pkg::ST_OUT && out_free) begin
			duty_q       <= (sum1 < lo_lim) ? pwm_low_q : sum1[23:16];
			iclamp_out_q <= iclamp_q;
			osat_q       <= osat1 || (sum1 < lo_lim);
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = {6'b0, osat_q, iclamp_out_q, duty_q};

	`PIDFF_ASSERT_NEXT(a_accept_starts, in_xfer, st_q == pidff_pkg::ST_EI_MUL, "accepted item did not start")
	`PIDFF_ASSERT_IMPL(a_done_issued, mdu_done, issued_q, "unit finished without a request")
	`PIDFF_ASSERT_IMPL(a_idle_quiet, st_q == pidff_pkg::ST_IDLE, !issued_q, "request pending while idle")

endmodule
